// ===== sv/btgr_pkg.sv =====
// Shared types, glyph ROM contents and row lookup helpers for the BCD time row renderer.
// No dependencies; every other file of the block imports this package.
package btgr_pkg;

	// Glyph ROM geometry: ten digits, then colon, then dot, sixteen rows each.
	localparam int unsigned GlyphCount = 12;
	localparam int unsigned FontRows   = 16;
	localparam logic [3:0] GLYPH_COLON = 4'd10;
	localparam logic [3:0] GLYPH_DOT   = 4'd11;
	localparam logic [3:0] DIGIT_LIMIT = 4'd10;

	// Font select codes.
	localparam logic FONT_THICK = 1'b0;
	localparam logic FONT_THIN  = 1'b1;

	// Request word: one row render.
	typedef struct packed {
		logic [23:0] time_bcd;
		logic        display_line;
		logic [2:0]  glyph_row;
	} req_word_t;

	// Response word: one row of pixels for both module halves.
	typedef struct packed {
		logic [31:0] left_pattern;
		logic [31:0] right_pattern;
		logic [3:0]  digit_register;
	} rsp_word_t;

	// Raw ROM rows after lookup, index 0 is the least significant nibble.
	typedef struct packed {
		logic [5:0][7:0] digit_rows;
		logic [2:0]      upper_zero;
		logic [7:0]      colon_row;
		logic [7:0]      dot_row;
		logic [3:0]      digit_register;
	} rows_word_t;

	// Rows after leading-zero blanking, ready to be placed.
	typedef struct packed {
		logic [5:0][7:0] digit_rows;
		logic [7:0]      colon_row;
		logic [7:0]      dot_row;
		logic [3:0]      digit_register;
	} glyphs_word_t;

	typedef logic [7:0] glyph_rom_t [0:1][0:GlyphCount-1][0:FontRows-1];

	localparam glyph_rom_t GLYPH_ROM = '{
		'{
			'{8'h3C,8'h3C,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,
			  8'hC3,8'hC3,8'hC3,8'hC3,8'h3C,8'h3C,8'h00,8'h00},
			'{8'h0C,8'h0C,8'h3C,8'h3C,8'h0C,8'h0C,8'h0C,8'h0C,
			  8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h3F,8'h00,8'h00},
			'{8'h3C,8'h3C,8'hC3,8'hC3,8'h03,8'h03,8'h0C,8'h0C,
			  8'hC0,8'hC0,8'hC0,8'hC0,8'hFF,8'hFF,8'h00,8'h00},
			'{8'h3C,8'h3C,8'hC3,8'hC3,8'h03,8'h03,8'h3C,8'h3C,
			  8'h03,8'h03,8'hC3,8'hC3,8'h3C,8'h3C,8'h00,8'h00},
			'{8'h03,8'h03,8'h0F,8'h0F,8'h33,8'h33,8'hC3,8'hC3,
			  8'hFF,8'hFF,8'h03,8'h03,8'h03,8'h03,8'h00,8'h00},
			'{8'hFF,8'hFF,8'hC0,8'hC0,8'hFC,8'hFC,8'h03,8'h03,
			  8'h03,8'h03,8'hC3,8'hC3,8'h3C,8'h3C,8'h00,8'h00},
			'{8'h3C,8'h3C,8'hC0,8'hC0,8'hC0,8'hC0,8'h3C,8'h3C,
			  8'hC3,8'hC3,8'hC3,8'hC3,8'h3C,8'h3C,8'h00,8'h00},
			'{8'hFF,8'hFF,8'h03,8'h03,8'h06,8'h06,8'h0C,8'h0C,
			  8'h18,8'h18,8'h30,8'h30,8'h60,8'h60,8'h00,8'h00},
			'{8'h3C,8'h3C,8'hC3,8'hC3,8'hC3,8'hC3,8'h3C,8'h3C,
			  8'hC3,8'hC3,8'hC3,8'hC3,8'h3C,8'h3C,8'h00,8'h00},
			'{8'h3C,8'h3C,8'hC3,8'hC3,8'hC3,8'hC3,8'h3C,8'h3C,
			  8'h03,8'h03,8'h03,8'h03,8'h3C,8'h3C,8'h00,8'h00},
			'{8'h00,8'h00,8'h00,8'h00,8'h06,8'h06,8'h00,8'h00,
			  8'h00,8'h00,8'h06,8'h06,8'h00,8'h00,8'h00,8'h00},
			'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
			  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h03,8'h03}
		},
		'{
			'{8'hFF,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,
			  8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'hFF},
			'{8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
			  8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01},
			'{8'hFF,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
			  8'hFF,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'hFF},
			'{8'hFF,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
			  8'hFF,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'hFF},
			'{8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,
			  8'hFF,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01},
			'{8'hFF,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
			  8'hFF,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'hFF},
			'{8'hFF,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
			  8'hFF,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'hFF},
			'{8'hFF,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
			  8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01},
			'{8'hFF,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,
			  8'hFF,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'hFF},
			'{8'hFF,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,
			  8'hFF,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'hFF},
			'{8'h00,8'h00,8'h00,8'h00,8'h04,8'h04,8'h00,8'h00,
			  8'h00,8'h00,8'h04,8'h04,8'h00,8'h00,8'h00,8'h00},
			'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
			  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01}
		}
	};

	// One ROM row of any glyph; glyph codes past the table read as blank.
	function automatic logic [7:0] glyph_bits(input logic font, input logic [3:0] glyph,
			input logic [3:0] row);
		logic [7:0] bits;
		bits = '0;
		if (glyph < 4'(GlyphCount)) begin
			bits = GLYPH_ROM[font][glyph][row];
		end
		return bits;
	endfunction

	// One ROM row of a digit nibble; nibble values of ten and above are blank.
	function automatic logic [7:0] digit_bits(input logic font, input logic [3:0] nib,
			input logic [3:0] row);
		logic [7:0] bits;
		bits = '0;
		if (nib < DIGIT_LIMIT) begin
			bits = glyph_bits(font, nib, row);
		end
		return bits;
	endfunction

endpackage

// ===== sv/btgr_lookup_stage.sv =====
// First pipeline stage: glyph ROM lookups for all six digits, the colon and the dot.
// Depends on btgr_pkg for the word types and the ROM helpers.
module btgr_lookup_stage import btgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       font_select,
	input  logic       up_valid,
	output logic       up_ready,
	input  req_word_t  up_word,
	output logic       dn_valid,
	input  logic       dn_ready,
	output rows_word_t dn_word
);

	logic       valid_s1;
	rows_word_t word_s1;
	rows_word_t word_next;
	logic [3:0] font_row;

	// Font row combines the module line and the pixel row.
	assign font_row = {up_word.display_line, up_word.glyph_row};

	// Look up every glyph row in parallel.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			word_next.digit_rows[i] = digit_bits(font_select, up_word.time_bcd[4*i +: 4], font_row);
		end
		for (int i = 0; i < 3; i++) begin
			word_next.upper_zero[i] = (up_word.time_bcd[12 + 4*i +: 4] == 4'd0);
		end
		word_next.colon_row      = glyph_bits(font_select, GLYPH_COLON, font_row);
		word_next.dot_row        = glyph_bits(font_select, GLYPH_DOT, font_row);
		word_next.digit_register = {1'b0, up_word.glyph_row} + 4'd1;
	end

	assign up_ready = !valid_s1 || dn_ready;

	// Stage register; loads whenever the stage is empty or draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= word_next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

endmodule

// ===== sv/btgr_blank_stage.sv =====
// Second pipeline stage: leading-zero blanking and colon gating on the upper digits.
// Depends on btgr_pkg for the word types.
module btgr_blank_stage import btgr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  rows_word_t   up_word,
	output logic         dn_valid,
	input  logic         dn_ready,
	output glyphs_word_t dn_word
);

	logic         valid_s2;
	glyphs_word_t word_s2;
	glyphs_word_t word_next;
	logic [7:0]   top_row;
	logic [7:0]   mid_row;
	logic         lit_top;
	logic         lit_mid;

	// A digit is drawn when it is nonzero or pixels to its left are already lit.
	always_comb begin
		top_row = up_word.upper_zero[2] ? 8'h00 : up_word.digit_rows[5];
		lit_top = (top_row != 8'h00);
		mid_row = (!up_word.upper_zero[1] || lit_top) ? up_word.digit_rows[4] : 8'h00;
		lit_mid = lit_top || (mid_row != 8'h00);

		word_next.digit_rows[5]   = top_row;
		word_next.digit_rows[4]   = mid_row;
		word_next.digit_rows[3]   = (!up_word.upper_zero[0] || lit_mid) ?
		                            up_word.digit_rows[3] : 8'h00;
		word_next.digit_rows[2:0] = up_word.digit_rows[2:0];
		word_next.colon_row       = lit_top ? up_word.colon_row : 8'h00;
		word_next.dot_row         = up_word.dot_row;
		word_next.digit_register  = up_word.digit_register;
	end

	assign up_ready = !valid_s2 || dn_ready;

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s2 <= word_next;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_word  = word_s2;

endmodule

// ===== sv/btgr_pack_stage.sv =====
// Third pipeline stage: places the glyph rows into the two 32-bit patterns.
// Depends on btgr_pkg for the word types; its register is the output register.
module btgr_pack_stage import btgr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  glyphs_word_t up_word,
	output logic         dn_valid,
	input  logic         dn_ready,
	output rsp_word_t    dn_word
);

	logic      valid_s3;
	rsp_word_t word_s3;
	rsp_word_t word_next;

	// Left half: top digit, colon, middle digit at 9-pixel pitch, low digit, dot.
	// Right half: three digits at 9-pixel pitch.
	always_comb begin
		word_next.left_pattern  = {up_word.digit_rows[5], 24'h0}
		                        | {4'h0, up_word.colon_row, 20'h0}
		                        | {12'h0, up_word.digit_rows[4], 12'h0}
		                        | {21'h0, up_word.digit_rows[3], 3'h0}
		                        | {24'h0, up_word.dot_row};
		word_next.right_pattern = {6'h0, up_word.digit_rows[2], 18'h0}
		                        | {15'h0, up_word.digit_rows[1], 9'h0}
		                        | {24'h0, up_word.digit_rows[0]};
		word_next.digit_register = up_word.digit_register;
	end

	assign up_ready = !valid_s3 || dn_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s3 <= word_next;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_word  = word_s3;

endmodule

// ===== sv/bcd_time_glyph_row_render.sv =====
// Top level of the BCD time row renderer: font register and three-stage pipeline.
// Depends on btgr_pkg, btgr_lookup_stage, btgr_blank_stage and btgr_pack_stage.
//
//   channel | signals                      | word
//   --------+------------------------------+---------------------------------------
//   req     | req_valid, req_ready, req    | time_bcd, display_line, glyph_row
//   rsp     | rsp_valid, rsp_ready, rsp    | left_pattern, right_pattern, digit_register
//   cfg     | cfg_valid, cfg_ready, font_select | font select, always ready
//
// A request passes the ROM lookup, blanking and packing registers in that order before its
// response is valid; each of the three holds one register stage. A new word is taken every
// cycle while the pipeline has a free slot.
// Reset clears the stage valid bits and sets the thin font.
// A stalled response holds the output register; each stage keeps taking words
// while it has a free slot, so a stall loses or repeats nothing.
module bcd_time_glyph_row_render import btgr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      font_select
);

	logic         font_q;
	logic         valid_s1;
	logic         ready_s1;
	rows_word_t   word_s1;
	logic         valid_s2;
	logic         ready_s2;
	glyphs_word_t word_s2;

	// Font select register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q <= FONT_THIN;
		end else if (cfg_valid && cfg_ready) begin
			font_q <= font_select;
		end
	end

	// Pipeline stages.
	btgr_lookup_stage u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.font_select(font_q),
		.up_valid   (req_valid),
		.up_ready   (req_ready),
		.up_word    (req),
		.dn_valid   (valid_s1),
		.dn_ready   (ready_s1),
		.dn_word    (word_s1)
	);

	btgr_blank_stage u_blank (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(valid_s1),
		.up_ready(ready_s1),
		.up_word (word_s1),
		.dn_valid(valid_s2),
		.dn_ready(ready_s2),
		.dn_word (word_s2)
	);

	btgr_pack_stage u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(valid_s2),
		.up_ready(ready_s2),
		.up_word (word_s2),
		.dn_valid(rsp_valid),
		.dn_ready(rsp_ready),
		.dn_word (rsp)
	);

	// The request side only backs up when every stage holds a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && valid_s2 && rsp_valid && !rsp_ready))
		else $error("request stalled with a free pipeline slot");

	// The driver digit code is the pixel row plus one, never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.digit_register != 4'd0 && rsp.digit_register <= 4'd8))
		else $error("digit register code out of range");

	// The right half places its leftmost digit at bit 18, so the top six bits stay dark.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.right_pattern[31:26] == 6'd0))
		else $error("right pattern lit beyond its top digit");

endmodule

// ===== sim/bcd_time_glyph_row_render_test.sv =====
// Self-checking testbench for bcd_time_glyph_row_render: random and directed row requests,
// checked against an independent row predictor with its own glyph tables.
// Depends on btgr_pkg and bcd_time_glyph_row_render.
module bcd_time_glyph_row_render_test;
	import btgr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_IDLE    = 6;

	// Glyph rows packed per glyph, font row 0 in the top byte.
	localparam logic [127:0] FONT_TABLE [0:1][0:11] = '{
		'{
			128'h3C3CC3C3C3C3C3C3_C3C3C3C33C3C0000,
			128'h0C0C3C3C0C0C0C0C_0C0C0C0C3F3F0000,
			128'h3C3CC3C303030C0C_C0C0C0C0FFFF0000,
			128'h3C3CC3C303033C3C_0303C3C33C3C0000,
			128'h03030F0F3333C3C3_FFFF030303030000,
			128'hFFFFC0C0FCFC0303_0303C3C33C3C0000,
			128'h3C3CC0C0C0C03C3C_C3C3C3C33C3C0000,
			128'hFFFF030306060C0C_1818303060600000,
			128'h3C3CC3C3C3C33C3C_C3C3C3C33C3C0000,
			128'h3C3CC3C3C3C33C3C_030303033C3C0000,
			128'h0000000006060000_0000060600000000,
			128'h0000000000000000_0000000000000303
		},
		'{
			128'hFF81818181818181_81818181818181FF,
			128'h0101010101010101_0101010101010101,
			128'hFF01010101010101_FF808080808080FF,
			128'hFF01010101010101_FF010101010101FF,
			128'h8181818181818181_FF01010101010101,
			128'hFF80808080808080_FF010101010101FF,
			128'hFF80808080808080_FF818181818181FF,
			128'hFF01010101010101_0101010101010101,
			128'hFF81818181818181_FF818181818181FF,
			128'hFF81818181818181_FF010101010101FF,
			128'h0000000004040000_0000040400000000,
			128'h0000000000000000_0000000000000001
		}
	};

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      req_valid   = 1'b0;
	logic      req_ready;
	req_word_t req         = '0;
	logic      rsp_valid;
	logic      rsp_ready   = 1'b0;
	rsp_word_t rsp;
	logic      cfg_valid   = 1'b0;
	logic      cfg_ready;
	logic      font_select = FONT_THICK;

	// Font the block should be using, tracked at each accepted register write.
	logic        font_now = FONT_THIN;
	rsp_word_t   expected_rows [$];
	int unsigned mismatch_count = 0;
	// No idling on either side while this is set.
	logic        burst = 1'b0;
	// Long receiver hold requested by a test, consumed by the response sink.
	int unsigned hold_off_cycles = 0;

	bcd_time_glyph_row_render dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.font_select (font_select)
	);

	always #5 clk = ~clk;

	// One byte of one glyph at a font row.
	function automatic logic [7:0] glyph_byte(input logic font, input logic [3:0] glyph,
			input logic [3:0] row);
		return FONT_TABLE[font][glyph][127 - 8 * row -: 8];
	endfunction

	// Digit byte; nibbles past nine are blank.
	function automatic logic [7:0] digit_byte(input logic font, input logic [3:0] nib,
			input logic [3:0] row);
		logic [7:0] bits;
		bits = '0;
		if (nib < DIGIT_LIMIT) begin
			bits = glyph_byte(font, nib, row);
		end
		return bits;
	endfunction

	// Pixel row for both module halves, with leading-zero and colon rules on the left.
	function automatic rsp_word_t render_row(input logic font, input req_word_t w);
		logic [31:0] left_acc;
		logic [31:0] right_acc;
		logic [3:0]  row;
		logic [3:0]  nib;
		rsp_word_t   r;
		row = {w.display_line, w.glyph_row};
		left_acc = '0;
		nib = w.time_bcd[23:20];
		if (nib != 4'd0) begin
			left_acc |= 32'(digit_byte(font, nib, row));
		end
		left_acc <<= 4;
		if (left_acc != 32'd0) begin
			left_acc |= 32'(glyph_byte(font, GLYPH_COLON, row));
		end
		left_acc <<= 8;
		nib = w.time_bcd[19:16];
		if (nib != 4'd0 || left_acc != 32'd0) begin
			left_acc |= 32'(digit_byte(font, nib, row));
		end
		left_acc <<= 9;
		nib = w.time_bcd[15:12];
		if (nib != 4'd0 || left_acc != 32'd0) begin
			left_acc |= 32'(digit_byte(font, nib, row));
		end
		left_acc <<= 3;
		left_acc |= 32'(glyph_byte(font, GLYPH_DOT, row));
		right_acc = 32'(digit_byte(font, w.time_bcd[11:8], row));
		right_acc <<= 9;
		right_acc |= 32'(digit_byte(font, w.time_bcd[7:4], row));
		right_acc <<= 9;
		right_acc |= 32'(digit_byte(font, w.time_bcd[3:0], row));
		r.left_pattern = left_acc;
		r.right_pattern = right_acc;
		r.digit_register = 4'(w.glyph_row) + 4'd1;
		return r;
	endfunction

	// Mostly all-decimal BCD times, some with leading zeros or blank nibbles, some raw.
	function automatic logic [23:0] random_time();
		logic [23:0] t;
		int unsigned k;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			return 24'($urandom);
		end
		for (k = 0; k < 6; k++) begin
			t[4*k +: 4] = 4'($urandom_range(0, 9));
		end
		if (pick < 5) begin
			t = t & (24'hFFFFFF >> (4 * $urandom_range(1, 4)));
		end else if (pick == 5) begin
			k = $urandom_range(0, 5);
			t[4*k +: 4] = 4'($urandom_range(10, 15));
		end
		return t;
	endfunction

	// Offer one request word and record its expected row once accepted.
	// Called and returns at a falling edge.
	task automatic send_word(input req_word_t w);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		expected_rows.push_back(render_row(font_now, w));
		@(negedge clk);
	endtask

	// Hold the request side until every expected row has come back.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (expected_rows.size() != 0) @(negedge clk);
	endtask

	// Write the font register while the block is idle.
	task automatic set_font(input logic font);
		drain_results();
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		font_select <= font;
		do @(posedge clk); while (!cfg_ready);
		font_now = font;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Extremes and the blanking, colon and empty-row cases, then a sweep of all font rows.
	task automatic test_directed();
		logic [23:0] times [0:8];
		logic [3:0]  rows  [0:8];
		req_word_t   w;
		int unsigned k;
		times = '{24'h000000, 24'h100000, 24'h100000, 24'hFFFFFF, 24'hABCDEF,
			24'h0A0000, 24'h001234, 24'h010000, 24'h999999};
		rows = '{4'd4, 4'd14, 4'd4, 4'd15, 4'd0, 4'd4, 4'd2, 4'd8, 4'd11};
		for (k = 0; k < 9; k++) begin
			w.time_bcd = times[k];
			{w.display_line, w.glyph_row} = rows[k];
			send_word(w);
		end
		for (k = 0; k < 16; k++) begin
			w.time_bcd = {6{4'(k % 10)}};
			{w.display_line, w.glyph_row} = 4'(k);
			send_word(w);
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming, then the sender waits.
	task automatic test_backpressure();
		req_word_t   w;
		int unsigned k;
		burst = 1'b1;
		hold_off_cycles = 60;
		for (k = 0; k < 40; k++) begin
			w.time_bcd = random_time();
			w.display_line = 1'($urandom_range(0, 1));
			w.glyph_row = 3'($urandom_range(0, 7));
			send_word(w);
		end
		drain_results();
		burst = 1'b0;
	endtask

	// Random requests, with no-idle stretches switched on now and then.
	task automatic test_random(input int unsigned count);
		req_word_t   w;
		int unsigned n;
		for (n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
			end
			w.time_bcd = random_time();
			w.display_line = 1'($urandom_range(0, 1));
			w.glyph_row = 3'($urandom_range(0, 7));
			send_word(w);
		end
		burst = 1'b0;
	endtask

	// Response side: random stall before each word, plus any long hold a test asks for.
	always begin : response_sink
		int unsigned stall;
		@(negedge clk);
		if (hold_off_cycles > 0) begin
			rsp_ready <= 1'b0;
			repeat (hold_off_cycles) @(negedge clk);
			hold_off_cycles = 0;
		end
		stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
		if (stall > 0) begin
			rsp_ready <= 1'b0;
			repeat (stall) @(negedge clk);
		end
		rsp_ready <= 1'b1;
		do @(posedge clk); while (!(arst_n && rsp_valid));
	end

	// Compare each accepted response word with the oldest expected row.
	always @(posedge clk) begin : row_checker
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rows.size() == 0) begin
				$error("response word %h with no request outstanding", rsp);
				mismatch_count++;
			end else begin
				want = expected_rows.pop_front();
				if (rsp.left_pattern !== want.left_pattern) begin
					$error("left_pattern expected %h actual %h",
						want.left_pattern, rsp.left_pattern);
					mismatch_count++;
				end
				if (rsp.right_pattern !== want.right_pattern) begin
					$error("right_pattern expected %h actual %h",
						want.right_pattern, rsp.right_pattern);
					mismatch_count++;
				end
				if (rsp.digit_register !== want.digit_register) begin
					$error("digit_register expected %h actual %h",
						want.digit_register, rsp.digit_register);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("bcd_time_glyph_row_render_test failed");
		$finish;
	end

	initial begin : run_tests
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// The first pass relies on the reset font.
		test_directed();
		set_font(FONT_THICK);
		test_directed();
		test_backpressure();
		test_random(700);
		set_font(FONT_THIN);
		test_random(700);
		set_font(FONT_THICK);
		test_random(300);
		set_font(FONT_THIN);
		test_random(300);
		drain_results();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && expected_rows.size() == 0) begin
			$display("bcd_time_glyph_row_render_test passed");
		end else begin
			$display("bcd_time_glyph_row_render_test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/btgr_pkg.sv
sv/btgr_lookup_stage.sv
sv/btgr_blank_stage.sv
sv/btgr_pack_stage.sv
sv/bcd_time_glyph_row_render.sv
sim/bcd_time_glyph_row_render_test.sv
